/* sv/mwm_pkg.sv */
package mwm_pkg;

    localparam int GRID_SIDE_DEF = 16;

    typedef logic [1:0] t_dir;
    typedef logic [1:0] t_wall;
    typedef logic [1:0] t_mode;

    localparam t_dir DIR_N = 2'd0;
    localparam t_dir DIR_E = 2'd1;
    localparam t_dir DIR_S = 2'd2;
    localparam t_dir DIR_W = 2'd3;

    localparam logic [2:0] DIR_BLOCKED = 3'd4;

    localparam t_wall W_ABSENT  = 2'd0;
    localparam t_wall W_PRESENT = 2'd1;
    localparam t_wall W_UNSEEN  = 2'd2;

    localparam t_mode MODE_REC  = 2'd0;
    localparam t_mode MODE_COST = 2'd1;
    localparam t_mode MODE_QRY  = 2'd2;

    localparam logic [7:0] COST_MAX   = 8'd255;
    localparam logic [7:0] WALLS_INIT = 8'hAA;

    function automatic t_wall wall_get(input logic [7:0] wbyte, input t_dir d);
        return wbyte[{d, 1'b0} +: 2];
    endfunction

    function automatic logic [7:0] wall_set(input logic [7:0] wbyte, input t_dir d,
                                            input t_wall v);
        logic [7:0] c;
        c = wbyte;
        c[{d, 1'b0} +: 2] = v;
        return c;
    endfunction

    // code three is taken as unseen
    function automatic t_wall wall_norm(input t_wall v);
        return (v == W_ABSENT || v == W_PRESENT) ? v : W_UNSEEN;
    endfunction

endpackage

/* sv/mwm_in_if.sv */
interface mwm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [3:0] row;
    logic [3:0] col;
    logic [1:0] heading;
    logic [1:0] wall_ahead;
    logic [1:0] wall_right;
    logic [1:0] wall_left;
    logic [7:0] cost_value;

    modport source (
        output valid, mode, row, col, heading, wall_ahead, wall_right, wall_left,
               cost_value,
        input  ready
    );
    modport sink (
        input  valid, mode, row, col, heading, wall_ahead, wall_right, wall_left,
               cost_value,
        output ready
    );
endinterface

/* sv/mwm_out_if.sv */
interface mwm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] next_dir;

    modport source (
        output valid, next_dir,
        input  ready
    );
    modport sink (
        input  valid, next_dir,
        output ready
    );
endinterface

/* sv/mwm_ram.sv */
module mwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/maze_wall_map_next_direction_unit.sv */
// channel | dir | handshake     | payload
// i_in    | in  | valid / ready | mode, row, col, heading, wall_ahead/right/left, cost_value
// o_out   | out | valid / ready | next_dir (query items only)
// i_cfg_* | in  | write enable  | unseen_policy
// A query makes one cost read per neighbour on the single read port of the cost
// RAM, and reads walls on the wall RAM port.
// After reset the wall RAM is swept with ready low.
// A query result waits in an output register; the block goes on taking items, and
// a second query finishing while the first is still untaken holds until it leaves.
module maze_wall_map_next_direction_unit #(
    parameter int GRID_SIDE = mwm_pkg::GRID_SIDE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    mwm_in_if.sink     i_in,
    mwm_out_if.source  o_out
);
    import mwm_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int IDX_W = $clog2(CELLS);
    localparam int RC_W  = $clog2(GRID_SIDE);

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_REC  = 6'b000100,
        S_WB   = 6'b001000,
        S_QRY  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } t_nbr;

    function automatic t_nbr nbr_of(input logic [3:0] r, input logic [3:0] c,
                                    input logic [IDX_W-1:0] idx, input t_dir d);
        t_nbr n;
        n.ok  = 1'b0;
        n.idx = idx;
        case (d)
            DIR_N: begin
                n.ok  = (32'(r) + 32'd1 < GRID_SIDE);
                n.idx = idx + IDX_W'(GRID_SIDE);
            end
            DIR_E: begin
                n.ok  = (32'(c) + 32'd1 < GRID_SIDE);
                n.idx = idx + IDX_W'(1);
            end
            DIR_S: begin
                n.ok  = (r != 4'd0);
                n.idx = idx - IDX_W'(GRID_SIDE);
            end
            DIR_W: begin
                n.ok  = (c != 4'd0);
                n.idx = idx - IDX_W'(1);
            end
            default: begin
                n.ok = 1'b0;
            end
        endcase
        return n;
    endfunction

    t_state            r_state, n_state;
    logic [2:0]        r_k, n_k;
    logic [3:0]        r_row, r_col;
    logic [IDX_W-1:0]  r_idx;
    t_dir              r_head;
    t_wall             r_wv [3];
    logic [7:0]        r_cell, n_cell;
    logic [7:0]        r_best_cost, n_best_cost;
    logic [2:0]        r_best_dir, n_best_dir;
    logic              r_policy;
    logic [IDX_W-1:0]  r_clr;
    logic [RC_W-1:0]   r_clr_row, r_clr_col;
    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_out_dir, n_out_dir;

    logic              accept, in_inside;
    logic [IDX_W-1:0]  in_idx;
    logic              wall_we, cost_we;
    logic [IDX_W-1:0]  wall_waddr, wall_raddr, cost_raddr;
    logic [7:0]        wall_wdata, wall_rd, cost_rd, clr_byte;
    t_dir              rec_iss, rec_prc, qry_iss, qry_prc;
    t_nbr              nb_rec_iss, nb_rec_prc, nb_qry_iss, nb_qry_prc;
    t_wall             rec_v, rec_f, mask;
    logic              q_open;

    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign in_inside   = (32'(i_in.row) < GRID_SIDE) && (32'(i_in.col) < GRID_SIDE);
    assign in_idx      = IDX_W'(32'(i_in.row) * GRID_SIDE + 32'(i_in.col));
    assign o_out.valid = r_out_valid;
    assign o_out.next_dir = r_out_dir;

    always_comb begin
        case (r_k[1:0])
            2'd0:    rec_iss = r_head;
            2'd1:    rec_iss = r_head + 2'd1;
            default: rec_iss = r_head + 2'd3;
        endcase
        case (r_k[1:0])
            2'd1:    rec_prc = r_head;
            2'd2:    rec_prc = r_head + 2'd1;
            default: rec_prc = r_head + 2'd3;
        endcase
    end

    assign qry_iss    = r_head + r_k[1:0];
    assign qry_prc    = r_head + r_k[1:0] - 2'd1;
    assign nb_rec_iss = nbr_of(r_row, r_col, r_idx, rec_iss);
    assign nb_rec_prc = nbr_of(r_row, r_col, r_idx, rec_prc);
    assign nb_qry_iss = nbr_of(r_row, r_col, r_idx, qry_iss);
    assign nb_qry_prc = nbr_of(r_row, r_col, r_idx, qry_prc);

    assign rec_v = (r_k[1:0] == 2'd1) ? r_wv[0] : (r_k[1:0] == 2'd2) ? r_wv[1] : r_wv[2];
    always_comb begin
        rec_f = wall_get(wall_rd, rec_prc + 2'd2);
        if (rec_f[1]) begin
            rec_f = rec_v;
        end
    end

    assign mask   = r_policy ? 2'b11 : 2'b01;
    assign q_open = ((wall_get(r_cell, qry_prc) & mask) == W_ABSENT) && nb_qry_prc.ok;

    always_comb begin
        clr_byte = WALLS_INIT;
        if (r_clr_row == RC_W'(GRID_SIDE - 1)) clr_byte = wall_set(clr_byte, DIR_N, W_PRESENT);
        if (r_clr_col == RC_W'(GRID_SIDE - 1)) clr_byte = wall_set(clr_byte, DIR_E, W_PRESENT);
        if (r_clr_row == '0) clr_byte = wall_set(clr_byte, DIR_S, W_PRESENT);
        if (r_clr_col == '0) clr_byte = wall_set(clr_byte, DIR_W, W_PRESENT);
    end

    always_comb begin
        wall_we    = 1'b0;
        wall_waddr = r_idx;
        wall_wdata = r_cell;
        wall_raddr = r_idx;
        cost_raddr = r_idx;
        cost_we    = accept && (i_in.mode == MODE_COST) && in_inside;
        case (r_state)
            S_CLR: begin
                wall_we    = 1'b1;
                wall_waddr = r_clr;
                wall_wdata = clr_byte;
            end
            S_IDLE: begin
                wall_raddr = in_idx;
                cost_raddr = in_idx;
            end
            S_REC: begin
                wall_raddr = nb_rec_iss.idx;
                wall_we    = (r_k != 3'd0) && nb_rec_prc.ok;
                wall_waddr = nb_rec_prc.idx;
                wall_wdata = wall_set(wall_rd, rec_prc + 2'd2, rec_f);
            end
            S_WB: begin
                wall_we = 1'b1;
            end
            S_QRY: begin
                cost_raddr = nb_qry_iss.idx;
            end
            default: begin
                wall_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_cell      = r_cell;
        n_best_cost = r_best_cost;
        n_best_dir  = r_best_dir;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_dir   = r_out_dir;
        case (r_state)
            S_CLR: begin
                if (r_clr == IDX_W'(CELLS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                n_k        = 3'd0;
                n_best_dir = DIR_BLOCKED;
                if (accept && i_in.mode == MODE_REC && in_inside) begin
                    n_state = S_REC;
                end else if (accept && i_in.mode == MODE_QRY) begin
                    n_state = in_inside ? S_QRY : S_DONE;
                end
            end
            S_REC: begin
                n_k = r_k + 3'd1;
                if (r_k == 3'd0) begin
                    n_cell = wall_rd;
                end else if (nb_rec_prc.ok) begin
                    n_cell = wall_set(r_cell, rec_prc, rec_f);
                end
                if (r_k == 3'd3) n_state = S_WB;
            end
            S_WB: begin
                n_state = S_IDLE;
            end
            S_QRY: begin
                n_k = r_k + 3'd1;
                if (r_k == 3'd0) begin
                    n_cell      = wall_rd;
                    n_best_cost = cost_rd;
                end else if (q_open && cost_rd < r_best_cost) begin
                    n_best_cost = cost_rd;
                    n_best_dir  = {1'b0, qry_prc};
                end
                if (r_k == 3'd4) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_dir   = (r_best_cost == COST_MAX) ? DIR_BLOCKED : r_best_dir;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_k         <= 3'd0;
            r_policy    <= 1'b0;
            r_clr       <= '0;
            r_clr_row   <= '0;
            r_clr_col   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            if (r_state == S_CLR) begin
                r_clr <= r_clr + IDX_W'(1);
                if (r_clr_col == RC_W'(GRID_SIDE - 1)) begin
                    r_clr_col <= '0;
                    r_clr_row <= r_clr_row + RC_W'(1);
                end else begin
                    r_clr_col <= r_clr_col + RC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell      <= n_cell;
        r_best_cost <= n_best_cost;
        r_best_dir  <= n_best_dir;
        r_out_dir   <= n_out_dir;
        if (accept) begin
            r_row   <= i_in.row;
            r_col   <= i_in.col;
            r_idx   <= in_idx;
            r_head  <= i_in.heading;
            r_wv[0] <= wall_norm(i_in.wall_ahead);
            r_wv[1] <= wall_norm(i_in.wall_right);
            r_wv[2] <= wall_norm(i_in.wall_left);
        end
    end

    mwm_ram #(.WIDTH(8), .DEPTH(CELLS)) u_wall_ram (
        .i_clk   (i_clk),
        .i_we    (wall_we),
        .i_waddr (wall_waddr),
        .i_wdata (wall_wdata),
        .i_raddr (wall_raddr),
        .o_rdata (wall_rd)
    );

    mwm_ram #(.WIDTH(8), .DEPTH(CELLS)) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (cost_we),
        .i_waddr (in_idx),
        .i_wdata (i_in.cost_value),
        .i_raddr (cost_raddr),
        .o_rdata (cost_rd)
    );

    // neighbour write and next neighbour read never hit the same cell
    a_rec_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REC && wall_we && r_k != 3'd3) |-> (wall_waddr != wall_raddr))
        else $error("record write collides with read");

    a_cost_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cost_we |-> (r_state == S_IDLE))
        else $error("cost write outside idle");

    a_clr_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR && r_clr == IDX_W'(CELLS - 1)) |=> (r_state == S_IDLE))
        else $error("clear pass did not end");

    a_qry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QRY) |-> (r_k <= 3'd4))
        else $error("query step out of range");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_dir <= DIR_BLOCKED))
        else $error("bad direction code");

endmodule
